>>> src/lfpa_pkg.sv
package lfpa_pkg;

    localparam int G_W          = 20;
    localparam int POS_W        = 24;
    localparam int DATA_W       = 32;
    localparam int FORCE_W      = 64;
    localparam int CFG_IDX_W    = 2;

    localparam int PHASE_BITS_DEF = 16;
    localparam int DOT_FRAC_W   = 26;
    localparam int TURN_BITS    = 32;

    localparam int CORDIC_STEPS = 16;
    localparam int CNT_W        = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam int MUL_W        = 33;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int TERM_SHIFT   = 30;
    localparam int F_SHIFT      = 10;
    localparam int F_W          = 54;
    localparam int FLO_W        = 26;
    localparam int GHI_W        = 48;
    localparam int GLO_W        = 47;
    localparam int FULL_W       = 75;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_X = 2'd0,
        REG_POS_Y = 2'd1,
        REG_POS_Z = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT,
        ST_DOT_WAIT,
        ST_CORDIC_INIT,
        ST_CORDIC,
        ST_QUAD,
        ST_TERM,
        ST_TERM_WAIT,
        ST_SAT,
        ST_VT,
        ST_VT_WAIT,
        ST_GF,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DOT,
        OP_TERM,
        OP_VT,
        OP_GHI,
        OP_GLO
    } mul_op_t;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    // arctangent of 2^-i in 2^32 units per turn
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [CNT_W-1:0] idx);
        logic signed [CORDIC_W-1:0] r;
        case (idx)
            4'd0:    r = 34'sd536870912;
            4'd1:    r = 34'sd316933406;
            4'd2:    r = 34'sd167458907;
            4'd3:    r = 34'sd85004756;
            4'd4:    r = 34'sd42667331;
            4'd5:    r = 34'sd21354465;
            4'd6:    r = 34'sd10679838;
            4'd7:    r = 34'sd5340245;
            4'd8:    r = 34'sd2670163;
            4'd9:    r = 34'sd1335087;
            4'd10:   r = 34'sd667544;
            4'd11:   r = 34'sd333772;
            4'd12:   r = 34'sd166886;
            4'd13:   r = 34'sd83443;
            4'd14:   r = 34'sd41722;
            4'd15:   r = 34'sd20861;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> src/local_force_phase_accumulate_core.sv
// channel  direction  handshake             payload
// cfg      in         cfg_we                cfg_index, cfg_data
// in       in         in_valid / in_stall   g_x, g_y, g_z, pot_factor, dens_re, dens_im, last_vec
// out      out        out_valid / out_stall force_x, force_y, force_z
//
// a new transaction is not accepted until the previous one is through the
// 16-step cordic and twelve passes through the one shared 33x33 multiplier
// a result waiting in the output register does not block the next accept, but a
// second result holds the block in its final cycle until the first is taken
// reset clears position, accumulators, sequencer and output valid
module local_force_phase_accumulate_core
    import lfpa_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [POS_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [G_W-1:0]       g_x,
    input  logic signed [G_W-1:0]       g_y,
    input  logic signed [G_W-1:0]       g_z,
    input  logic signed [DATA_W-1:0]    pot_factor,
    input  logic signed [DATA_W-1:0]    dens_re,
    input  logic signed [DATA_W-1:0]    dens_im,
    input  logic                        last_vec,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [FORCE_W-1:0]   force_x,
    output logic signed [FORCE_W-1:0]   force_y,
    output logic signed [FORCE_W-1:0]   force_z
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;

    logic signed [G_W-1:0]    gx_reg, gy_reg, gz_reg;
    logic signed [DATA_W-1:0] v_reg, are_reg, aim_reg;
    logic                     last_reg;

    logic [DOT_FRAC_W-1:0]        dot_reg;
    logic signed [CORDIC_W-1:0]   x_reg, y_reg, z_reg;
    quad_t                        quad_reg;
    logic signed [CORDIC_W-1:0]   c_reg, s_reg;
    logic signed [PROD_W-1:0]     term_reg;
    logic signed [DATA_W-1:0]     t_reg;
    logic signed [F_W-1:0]        f_reg;
    logic signed [GHI_W-1:0]      hi_reg;
    logic signed [FORCE_W-1:0]    contrib_reg;
    logic [1:0]                   contrib_k_reg;
    logic                         contrib_vld_reg;

    logic signed [PROD_W-1:0]     prod_reg;
    mul_op_t                      tag_reg;
    logic [1:0]                   tag_k_reg;

    logic signed [FORCE_W-1:0]    acc_x_reg, acc_y_reg, acc_z_reg;
    logic signed [FORCE_W-1:0]    force_x_reg, force_y_reg, force_z_reg;
    logic                         out_valid_reg;

    // shared multiplier
    mul_op_t                  mul_op;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic [1:0]               mul_k;
    logic signed [PROD_W-1:0] prod_next;
    logic [1:0]               g_idx;
    logic signed [G_W-1:0]    g_sel;

    logic in_accept, emit_go;

    assign in_accept = in_valid && !in_stall;
    assign emit_go   = (state_reg == ST_EMIT) && !(last_reg && out_valid_reg && out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT:
            begin
                if (cnt_reg == CNT_W'(2))
                begin
                    state_next = ST_DOT_WAIT;
                    cnt_next   = '0;
                end
            end
            ST_DOT_WAIT:    state_next = ST_CORDIC_INIT;
            ST_CORDIC_INIT:
            begin
                state_next = ST_CORDIC;
                cnt_next   = '0;
            end
            ST_CORDIC:
            begin
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_QUAD;
                    cnt_next   = '0;
                end
            end
            ST_QUAD:
            begin
                state_next = ST_TERM;
                cnt_next   = '0;
            end
            ST_TERM:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_TERM_WAIT;
                    cnt_next   = '0;
                end
            end
            ST_TERM_WAIT:   state_next = ST_SAT;
            ST_SAT:         state_next = ST_VT;
            ST_VT:          state_next = ST_VT_WAIT;
            ST_VT_WAIT:
            begin
                state_next = ST_GF;
                cnt_next   = '0;
            end
            ST_GF:
            begin
                if (cnt_reg == CNT_W'(5))
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake and multiplier operands
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        mul_op   = OP_NONE;
        mul_a    = '0;
        mul_b    = '0;
        mul_k    = cnt_reg[2:1];
        g_idx    = (state_reg == ST_DOT) ? cnt_reg[1:0] : cnt_reg[2:1];
        case (g_idx)
            2'd0:    g_sel = gx_reg;
            2'd1:    g_sel = gy_reg;
            default: g_sel = gz_reg;
        endcase
        case (state_reg)
            ST_DOT:
            begin
                mul_op = OP_DOT;
                mul_a  = MUL_W'(g_sel);
                case (cnt_reg[1:0])
                    2'd0:    mul_b = MUL_W'(pos_x_reg);
                    2'd1:    mul_b = MUL_W'(pos_y_reg);
                    default: mul_b = MUL_W'(pos_z_reg);
                endcase
            end
            ST_TERM:
            begin
                mul_op = OP_TERM;
                if (cnt_reg[0])
                begin
                    mul_a = $signed(s_reg[MUL_W-1:0]);
                    mul_b = MUL_W'(are_reg);
                end
                else
                begin
                    mul_a = $signed(c_reg[MUL_W-1:0]);
                    mul_b = MUL_W'(aim_reg);
                end
            end
            ST_VT:
            begin
                mul_op = OP_VT;
                mul_a  = MUL_W'(v_reg);
                mul_b  = MUL_W'(t_reg);
            end
            ST_GF:
            begin
                mul_a = MUL_W'(g_sel);
                if (cnt_reg[0])
                begin
                    mul_op = OP_GLO;
                    mul_b  = $signed({{(MUL_W-FLO_W){1'b0}}, f_reg[FLO_W-1:0]});
                end
                else
                begin
                    mul_op = OP_GHI;
                    mul_b  = MUL_W'($signed(f_reg[F_W-1:FLO_W]));
                end
            end
            default:
            begin
                mul_op = OP_NONE;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // datapath helpers
    logic [PHASE_BITS-1:0]        phase;
    logic signed [CORDIC_W-1:0]   z_init;
    logic signed [CORDIC_W-1:0]   x_sh, y_sh, atan_val;
    logic signed [PROD_W-1:0]     t_wide;
    logic signed [DATA_W-1:0]     t_sat;
    logic signed [FULL_W-1:0]     full;
    logic signed [FORCE_W-1:0]    contrib_sat;
    logic signed [FORCE_W-1:0]    acc_sel;
    logic signed [FORCE_W:0]      acc_sum;
    logic signed [FORCE_W-1:0]    acc_new;

    assign phase    = dot_reg[DOT_FRAC_W-1 -: PHASE_BITS];
    assign z_init   = CORDIC_W'(phase[PHASE_BITS-3:0]) << (TURN_BITS - PHASE_BITS);
    assign x_sh     = x_reg >>> cnt_reg;
    assign y_sh     = y_reg >>> cnt_reg;
    assign atan_val = atan_turn(cnt_reg);

    always_comb
    begin
        t_wide = term_reg >>> TERM_SHIFT;
        if ((&t_wide[PROD_W-1:DATA_W-1]) || !(|t_wide[PROD_W-1:DATA_W-1]))
        begin
            t_sat = t_wide[DATA_W-1:0];
        end
        else
        begin
            t_sat = {t_wide[PROD_W-1], {(DATA_W-1){!t_wide[PROD_W-1]}}};
        end
    end

    // g*f = (g*f_hi << FLO_W) + g*f_lo, then clamp to 64 bits
    always_comb
    begin
        full = FULL_W'($signed({hi_reg, {FLO_W{1'b0}}})) + FULL_W'($signed(prod_reg[GLO_W-1:0]));
        if ((&full[FULL_W-1:FORCE_W-1]) || !(|full[FULL_W-1:FORCE_W-1]))
        begin
            contrib_sat = full[FORCE_W-1:0];
        end
        else
        begin
            contrib_sat = {full[FULL_W-1], {(FORCE_W-1){!full[FULL_W-1]}}};
        end
    end

    always_comb
    begin
        case (contrib_k_reg)
            2'd0:    acc_sel = acc_x_reg;
            2'd1:    acc_sel = acc_y_reg;
            default: acc_sel = acc_z_reg;
        endcase
        acc_sum = (FORCE_W+1)'(acc_sel) + (FORCE_W+1)'(contrib_reg);
        if (acc_sum[FORCE_W] != acc_sum[FORCE_W-1])
        begin
            acc_new = {acc_sum[FORCE_W], {(FORCE_W-1){!acc_sum[FORCE_W]}}};
        end
        else
        begin
            acc_new = acc_sum[FORCE_W-1:0];
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            pos_z_reg       <= '0;
            tag_reg         <= OP_NONE;
            contrib_vld_reg <= 1'b0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            acc_z_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tag_reg   <= mul_op;

            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_POS_X: pos_x_reg <= $signed(cfg_data);
                    REG_POS_Y: pos_y_reg <= $signed(cfg_data);
                    REG_POS_Z: pos_z_reg <= $signed(cfg_data);
                    default:   ;
                endcase
            end

            contrib_vld_reg <= (tag_reg == OP_GLO);

            if (contrib_vld_reg)
            begin
                case (contrib_k_reg)
                    2'd0:    acc_x_reg <= acc_new;
                    2'd1:    acc_y_reg <= acc_new;
                    default: acc_z_reg <= acc_new;
                endcase
            end

            if (emit_go && last_reg)
            begin
                out_valid_reg <= 1'b1;
                acc_x_reg     <= '0;
                acc_y_reg     <= '0;
                acc_z_reg     <= '0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        tag_k_reg     <= mul_k;
        contrib_k_reg <= tag_k_reg;
        contrib_reg   <= contrib_sat;

        if (in_accept)
        begin
            gx_reg   <= g_x;
            gy_reg   <= g_y;
            gz_reg   <= g_z;
            v_reg    <= pot_factor;
            are_reg  <= dens_re;
            aim_reg  <= dens_im;
            last_reg <= last_vec;
            dot_reg  <= '0;
        end

        case (tag_reg)
            OP_DOT:  dot_reg  <= dot_reg + prod_reg[DOT_FRAC_W-1:0];
            OP_TERM: term_reg <= term_reg + prod_reg;
            OP_VT:   f_reg    <= prod_reg[F_SHIFT+F_W-1:F_SHIFT];
            OP_GHI:  hi_reg   <= prod_reg[GHI_W-1:0];
            default: ;
        endcase

        case (state_reg)
            ST_CORDIC_INIT:
            begin
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= z_init;
                quad_reg <= quad_t'(phase[PHASE_BITS-1 -: 2]);
                term_reg <= '0;
            end
            ST_CORDIC:
            begin
                if (!z_reg[CORDIC_W-1])
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - atan_val;
                end
                else
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + atan_val;
                end
            end
            ST_QUAD:
            begin
                case (quad_reg)
                    QUAD_0:
                    begin
                        c_reg <= x_reg;
                        s_reg <= y_reg;
                    end
                    QUAD_1:
                    begin
                        c_reg <= -y_reg;
                        s_reg <= x_reg;
                    end
                    QUAD_2:
                    begin
                        c_reg <= -x_reg;
                        s_reg <= -y_reg;
                    end
                    default:
                    begin
                        c_reg <= y_reg;
                        s_reg <= -x_reg;
                    end
                endcase
            end
            ST_SAT:  t_reg <= t_sat;
            default: ;
        endcase

        if (emit_go && last_reg)
        begin
            force_x_reg <= acc_x_reg;
            force_y_reg <= acc_y_reg;
            force_z_reg <= acc_z_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign force_x   = force_x_reg;
    assign force_y   = force_y_reg;
    assign force_z   = force_z_reg;

endmodule

>>> src/lfpa_checker.sv
module lfpa_checker
    import lfpa_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [FORCE_W-1:0] force_x,
    input logic signed [FORCE_W-1:0] force_y,
    input logic signed [FORCE_W-1:0] force_z
);

    // one transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while previous transaction still in work");

    // a new result only comes out of a transaction in work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a transaction in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            ($stable(force_x) && $stable(force_y) && $stable(force_z)))
        else $error("output payload changed while stalled");

endmodule

bind local_force_phase_accumulate_core lfpa_checker u_lfpa_checker (.*);
